FILE: src/coo_spmm_row_accumulate_defines.svh
// assertion macros used by the checker file
// clocked on clk, disabled while arst_n is low
`ifndef COO_SPMM_ROW_ACCUMULATE_DEFINES_SVH
`define COO_SPMM_ROW_ACCUMULATE_DEFINES_SVH

// property given whole, implication written by the caller
`define COO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// overlapping implication from antecedent to consequent
`define COO_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/coo_sra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sra_pkg
// types, codes and defaults shared by the coo spmm row accumulate block
// ----------------------------------------------------------------------------
package coo_sra_pkg;

	localparam int FEATURES_MAX_DEF = 16;
	localparam int OUT_ROWS_DEF     = 1024;
	localparam int IN_ROWS_DEF      = 1024;

	localparam int FC_W        = 5;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [FC_W-1:0] FEATURE_COUNT_RST = 5'd16;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_ACCUM = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_READ  = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_ACCUM,
		OP_CLEAR,
		OP_READ,
		OP_READ_ZERO
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_CLR,
		ST_RD
	} back_state_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [9:0]         row_index;
		logic [9:0]         col_index;
		logic [3:0]         feature_index;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               overflow_seen;
	} rsp_t;

endpackage

FILE: src/coo_sra_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sra_queue
// small fifo of classified items between the front and the back
// ----------------------------------------------------------------------------
module coo_sra_queue import coo_sra_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty,
	output logic         full
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [W-1:0] mem_q [QUEUE_DEPTH];
	logic [AW:0]  wr_ptr_q;
	logic [AW:0]  rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) && (wr_ptr_q[AW] != rd_ptr_q[AW]);
	assign head  = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty)
				rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q[AW-1:0]] <= push_data;
	end

endmodule

FILE: src/coo_sra_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sra_front
// accepts items, checks ranges, classifies them and forms memory addresses
// ----------------------------------------------------------------------------
module coo_sra_front import coo_sra_pkg::*; #(
	parameter int FEATURES_MAX = FEATURES_MAX_DEF,
	parameter int OUT_ROWS     = OUT_ROWS_DEF,
	parameter int IN_ROWS      = IN_ROWS_DEF,
	parameter int XAW          = 14,
	parameter int YAW          = 14
) (
	input  req_t                req,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                q_full,
	output logic                q_push,
	output op_t                 q_op,
	output logic [XAW-1:0]      q_x_addr,
	output logic [YAW-1:0]      q_y_addr,
	output logic signed [31:0]  q_value
);

	localparam logic [16:0] IN_ROWS_W  = 17'(IN_ROWS);
	localparam logic [16:0] OUT_ROWS_W = 17'(OUT_ROWS);
	localparam logic [6:0]  FEAT_W     = 7'(FEATURES_MAX);

	logic col_ok;
	logic row_ok;
	logic feat_ok;
	logic keep;
	logic [XAW-1:0] x_off;
	logic [YAW-1:0] y_off;

	assign col_ok  = 17'(req.col_index) < IN_ROWS_W;
	assign row_ok  = 17'(req.row_index) < OUT_ROWS_W;
	assign feat_ok = 7'(req.feature_index) < FEAT_W;

	always_comb begin
		keep  = 1'b0;
		q_op  = OP_LOAD;
		x_off = '0;
		y_off = '0;
		case (req.req_type)
			REQ_LOAD: begin
				keep  = col_ok && feat_ok;
				q_op  = OP_LOAD;
				x_off = XAW'(req.feature_index);
			end
			REQ_ACCUM: begin
				keep = col_ok && row_ok;
				q_op = OP_ACCUM;
			end
			REQ_CLEAR: begin
				keep = row_ok;
				q_op = OP_CLEAR;
			end
			REQ_READ: begin
				keep  = 1'b1;
				q_op  = (row_ok && feat_ok) ? OP_READ : OP_READ_ZERO;
				y_off = YAW'(req.feature_index);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req_ready = !q_full;
	assign q_push    = req_valid && !q_full && keep;
	assign q_x_addr  = XAW'(req.col_index) * XAW'(FEATURES_MAX) + x_off;
	assign q_y_addr  = YAW'(req.row_index) * YAW'(FEATURES_MAX) + y_off;
	assign q_value   = req.value;

endmodule

FILE: src/coo_sra_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sra_back
// executes queued items against the x and y memories, one item at a time
// ----------------------------------------------------------------------------
module coo_sra_back import coo_sra_pkg::*; #(
	parameter int FEATURES_MAX = FEATURES_MAX_DEF,
	parameter int OUT_ROWS     = OUT_ROWS_DEF,
	parameter int IN_ROWS      = IN_ROWS_DEF,
	parameter int XAW          = 14,
	parameter int YAW          = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FC_W-1:0]     feature_count,
	input  logic                q_empty,
	input  op_t                 q_op,
	input  logic [XAW-1:0]      q_x_addr,
	input  logic [YAW-1:0]      q_y_addr,
	input  logic signed [31:0]  q_value,
	output logic                q_pop,
	output rsp_t                rsp,
	output logic                rsp_valid,
	input  logic                rsp_ready
);

	localparam int XDEPTH = IN_ROWS * FEATURES_MAX;
	localparam int YDEPTH = OUT_ROWS * FEATURES_MAX;
	localparam int NW0    = $clog2(FEATURES_MAX + 1);
	localparam int NW     = (NW0 > FC_W) ? NW0 : FC_W;
	localparam int FW     = (FEATURES_MAX > 1) ? $clog2(FEATURES_MAX) : 1;

	logic [31:0] x_mem [XDEPTH];
	logic [31:0] y_mem [YDEPTH];

	back_state_t state_q, state_d;
	logic [NW-1:0]      cnt_q, cnt_d;
	logic [NW-1:0]      n_act;
	logic [XAW-1:0]     x_base_q;
	logic [YAW-1:0]     y_base_q;
	logic signed [31:0] value_q;
	logic               ovf_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [31:0]        x_rd_q;
	logic [31:0]        y_rd_q;
	logic               v_s1;
	logic [YAW-1:0]     y_addr_s1;
	logic               v_s2;
	logic [YAW-1:0]     y_addr_s2;
	logic signed [63:0] prod_s2;
	logic [31:0]        y_old_s2;

	logic               latch;
	logic               issue;
	logic               x_we;
	logic               clr_we;
	logic               out_set;
	logic               out_zero;
	logic               out_free;
	logic               last;
	logic [XAW-1:0]     x_ra;
	logic [YAW-1:0]     y_ra;
	logic [YAW-1:0]     y_row_addr;
	logic               y_we;
	logic [YAW-1:0]     y_wa;
	logic [31:0]        y_wd;

	logic signed [63:0] prod_sh;
	logic [48:0]        sum;
	logic               sat_hi;
	logic               sat_lo;
	logic [31:0]        sat;

	assign n_act = (NW'(feature_count) > NW'(FEATURES_MAX)) ? NW'(FEATURES_MAX)
		: NW'(feature_count);
	assign last       = (cnt_q == n_act - 1'b1);
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign x_ra       = x_base_q + XAW'(cnt_q[FW-1:0]);
	assign y_row_addr = y_base_q + YAW'(cnt_q[FW-1:0]);
	assign y_ra       = (state_q == ST_IDLE) ? q_y_addr : y_row_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		q_pop    = 1'b0;
		latch    = 1'b0;
		issue    = 1'b0;
		x_we     = 1'b0;
		clr_we   = 1'b0;
		out_set  = 1'b0;
		out_zero = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_op)
						OP_LOAD: begin
							x_we  = 1'b1;
							q_pop = 1'b1;
						end
						OP_ACCUM: begin
							q_pop = 1'b1;
							if (n_act != '0) begin
								latch   = 1'b1;
								cnt_d   = '0;
								state_d = ST_ACC;
							end
						end
						OP_CLEAR: begin
							q_pop = 1'b1;
							if (n_act != '0) begin
								latch   = 1'b1;
								cnt_d   = '0;
								state_d = ST_CLR;
							end
						end
						OP_READ: begin
							if (out_free) begin
								q_pop   = 1'b1;
								state_d = ST_RD;
							end
						end
						OP_READ_ZERO: begin
							if (out_free) begin
								q_pop    = 1'b1;
								out_set  = 1'b1;
								out_zero = 1'b1;
							end
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_ACC: begin
				issue = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2)
					state_d = ST_IDLE;
			end
			ST_CLR: begin
				clr_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (last)
					state_d = ST_IDLE;
			end
			ST_RD: begin
				out_set = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// accumulate datapath: floor shift, add, saturate
	assign prod_sh = prod_s2 >>> 16;
	assign sum     = {{17{y_old_s2[31]}}, y_old_s2} + prod_sh[48:0];
	assign sat_hi  = !sum[48] && (|sum[47:31]);
	assign sat_lo  = sum[48] && !(&sum[47:31]);
	assign sat     = sat_hi ? 32'h7fff_ffff : (sat_lo ? 32'h8000_0000 : sum[31:0]);

	assign y_we = v_s2 || clr_we;
	assign y_wa = v_s2 ? y_addr_s2 : y_row_addr;
	assign y_wd = v_s2 ? sat : 32'h0;

	always_ff @(posedge clk) begin
		if (x_we)
			x_mem[q_x_addr] <= q_value;
		x_rd_q <= x_mem[x_ra];
	end

	always_ff @(posedge clk) begin
		if (y_we)
			y_mem[y_wa] <= y_wd;
		y_rd_q <= y_mem[y_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			v_s1  <= issue;
			v_s2  <= v_s1;
			if (v_s2 && (sat_hi || sat_lo))
				ovf_q <= 1'b1;
			if (out_set)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (latch) begin
			x_base_q <= q_x_addr;
			y_base_q <= q_y_addr;
			value_q  <= q_value;
		end
		y_addr_s1 <= y_row_addr;
		y_addr_s2 <= y_addr_s1;
		prod_s2   <= 64'($signed(x_rd_q)) * 64'(value_q);
		y_old_s2  <= y_rd_q;
		if (out_set) begin
			rsp_q.read_value    <= out_zero ? 32'sh0 : $signed(y_rd_q);
			rsp_q.overflow_seen <= ovf_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: src/coo_spmm_row_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_spmm_row_accumulate
// sparse times dense product engine fed with coo nonzeros, x and y in memory
// ----------------------------------------------------------------------------
// the front takes one item per cycle into a four-entry queue while it has
// room; the back executes one queued item at a time. a clear or a nonzero
// covers n features, where n is feature_count capped at FEATURES_MAX; a
// read whose row or feature is out of range gives zero without a y read.
// a nonzero uses the single multiply-accumulate lane doing a read-modify-
// write of one y entry per cycle, followed by a drain of the s1 and s2
// stages before the next item starts. a read waits for the response
// register to be free; other items keep running while a response is held.
module coo_spmm_row_accumulate import coo_sra_pkg::*; #(
	parameter int FEATURES_MAX = FEATURES_MAX_DEF,
	parameter int OUT_ROWS     = OUT_ROWS_DEF,
	parameter int IN_ROWS      = IN_ROWS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  req_t            req,
	input  logic            req_valid,
	output logic            req_ready,
	output rsp_t            rsp,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  logic [FC_W-1:0] cfg_data,
	input  logic            cfg_valid,
	output logic            cfg_ready
);

	localparam int XDEPTH = IN_ROWS * FEATURES_MAX;
	localparam int YDEPTH = OUT_ROWS * FEATURES_MAX;
	localparam int XAW    = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
	localparam int YAW    = (YDEPTH > 1) ? $clog2(YDEPTH) : 1;
	localparam int OPW    = $bits(op_t);
	localparam int QW     = OPW + XAW + YAW + 32;

	logic [FC_W-1:0]    feature_count_q;
	logic               q_push;
	logic               q_pop;
	logic               q_empty;
	logic               q_full;
	op_t                f_op;
	logic [XAW-1:0]     f_x_addr;
	logic [YAW-1:0]     f_y_addr;
	logic signed [31:0] f_value;
	logic [QW-1:0]      q_head;
	op_t                b_op;
	logic [XAW-1:0]     b_x_addr;
	logic [YAW-1:0]     b_y_addr;
	logic signed [31:0] b_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			feature_count_q <= FEATURE_COUNT_RST;
		else if (cfg_valid)
			feature_count_q <= cfg_data;
	end

	coo_sra_front #(
		.FEATURES_MAX (FEATURES_MAX),
		.OUT_ROWS     (OUT_ROWS),
		.IN_ROWS      (IN_ROWS),
		.XAW          (XAW),
		.YAW          (YAW)
	) u_front (
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (f_op),
		.q_x_addr  (f_x_addr),
		.q_y_addr  (f_y_addr),
		.q_value   (f_value)
	);

	coo_sra_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_op, f_x_addr, f_y_addr, f_value}),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	assign b_op     = op_t'(q_head[QW-1 -: OPW]);
	assign b_x_addr = q_head[XAW+YAW+31 -: XAW];
	assign b_y_addr = q_head[YAW+31 -: YAW];
	assign b_value  = $signed(q_head[31:0]);

	coo_sra_back #(
		.FEATURES_MAX (FEATURES_MAX),
		.OUT_ROWS     (OUT_ROWS),
		.IN_ROWS      (IN_ROWS),
		.XAW          (XAW),
		.YAW          (YAW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.feature_count (feature_count_q),
		.q_empty       (q_empty),
		.q_op          (b_op),
		.q_x_addr      (b_x_addr),
		.q_y_addr      (b_y_addr),
		.q_value       (b_value),
		.q_pop         (q_pop),
		.rsp           (rsp),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready)
	);

endmodule

FILE: src/coo_sra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coo_sra_checker
// port-level checks on the coo spmm row accumulate block, bound to the top
// ----------------------------------------------------------------------------
`include "coo_spmm_row_accumulate_defines.svh"

module coo_sra_checker import coo_sra_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input req_t            req,
	input logic            req_valid,
	input logic            req_ready,
	input rsp_t            rsp,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic [FC_W-1:0] cfg_data,
	input logic            cfg_valid,
	input logic            cfg_ready
);

	logic [3:0] pend_q;
	logic       ovf_seen_q;
	logic       rd_acc;
	logic       rsp_acc;

	assign rd_acc  = req_valid && req_ready && (req.req_type == REQ_READ);
	assign rsp_acc = rsp_valid && rsp_ready;

	// outstanding read items and sticky overflow as seen at the ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			ovf_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + {3'b0, rd_acc} - {3'b0, rsp_acc};
			if (rsp_acc && rsp.overflow_seen)
				ovf_seen_q <= 1'b1;
		end
	end

	`COO_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp dropped")
	`COO_ASSERT_IMPL(a_rsp_has_read, rsp_valid, pend_q != 4'd0, "rsp without read item")
	`COO_ASSERT_IMPL(a_ovf_sticky, rsp_valid && ovf_seen_q, rsp.overflow_seen, "overflow cleared")
	`COO_ASSERT_IMPL(a_cfg_ready, cfg_valid && (cfg_data != 5'd0), cfg_ready, "cfg stalled")

endmodule

bind coo_spmm_row_accumulate coo_sra_checker u_coo_sra_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks coo_spmm_row_accumulate against a built-in model of x, y and the
// sticky overflow flag: a short directed table, then random phases under
// several feature counts, with random stalls on both channels, a stretch with
// no stalls and one long response hold that backs up the request queue
// ----------------------------------------------------------------------------
module testbench;
	import coo_sra_pkg::*;

	localparam int FMAX          = FEATURES_MAX_DEF;
	localparam int X_DEPTH       = IN_ROWS_DEF * FEATURES_MAX_DEF;
	localparam int Y_DEPTH       = OUT_ROWS_DEF * FEATURES_MAX_DEF;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 5000;
	localparam int NPHASES       = 8;

	localparam logic [FC_W-1:0] PHASE_FC [NPHASES] = '{5'd16, 5'd1, 5'd31, 5'd0,
		5'd5, 5'd17, 5'd12, 5'd16};
	localparam int PHASE_ITEMS [NPHASES] = '{200, 150, 150, 100, 150, 150, 150, 100};
	localparam logic [9:0] HOT_INDEX [8] = '{10'h000, 10'h001, 10'h002, 10'h007,
		10'h155, 10'h2AA, 10'h3FE, 10'h3FF};
	localparam logic [31:0] EDGE_VALUES [5] = '{32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};

	typedef struct {
		bit              is_cfg;
		logic [FC_W-1:0] cfg;
		req_t            item;
		bit              typed;
		rsp_t            want;
	} step_t;

	typedef struct {
		bit   typed;
		rsp_t want;
	} read_note_t;

	logic            clk;
	logic            arst_n;
	req_t            req;
	logic            req_valid;
	logic            req_ready;
	rsp_t            rsp;
	logic            rsp_valid;
	logic            rsp_ready;
	logic [FC_W-1:0] cfg_data;
	logic            cfg_valid;
	logic            cfg_ready;

	// model state, advanced on accepted items
	logic signed [31:0] x_mem [X_DEPTH];
	logic signed [31:0] y_mem [Y_DEPTH];
	logic               ovf_flag;
	logic [FC_W-1:0]    fc_model;

	// which entries hold data, tracked as items are sent
	bit              x_set [X_DEPTH];
	bit              y_set [Y_DEPTH];
	logic [FC_W-1:0] fc_gen;

	rsp_t       expected_reads [$];
	read_note_t read_notes [$];
	step_t      directed_steps [$];

	bit no_idle;
	bit hold_rsp;
	int dead_cycles;
	int mismatches;
	int items_sent;
	int reads_checked;
	int cfg_writes;
	int holds_done;

	coo_spmm_row_accumulate u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_data  (cfg_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int active_n(input logic [FC_W-1:0] fc);
		return (fc > FMAX) ? FMAX : int'(fc);
	endfunction

	function automatic logic [9:0] pick_index();
		if ($urandom_range(0, 99) < 85)
			return HOT_INDEX[$urandom_range(0, 7)];
		return 10'($urandom_range(0, 1023));
	endfunction

	// one item against the model; returns 1 when it yields a response
	function automatic bit spmm_predict(input req_t r, output rsp_t out);
		int     n;
		int     xi;
		int     yi;
		int     f;
		longint prod;
		longint total;
		n = active_n(fc_model);
		xi = int'(r.col_index) * FMAX;
		yi = int'(r.row_index) * FMAX;
		out = '0;
		case (r.req_type)
			REQ_LOAD: begin
				x_mem[xi + int'(r.feature_index)] = r.value;
			end
			REQ_ACCUM: begin
				for (f = 0; f < n; f++) begin
					prod = longint'($signed(r.value)) * longint'(x_mem[xi + f]);
					total = longint'(y_mem[yi + f]) + (prod >>> 16);
					if (total > 64'sd2147483647) begin
						total = 64'sd2147483647;
						ovf_flag = 1'b1;
					end else if (total < -64'sd2147483648) begin
						total = -64'sd2147483648;
						ovf_flag = 1'b1;
					end
					y_mem[yi + f] = total[31:0];
				end
			end
			REQ_CLEAR: begin
				for (f = 0; f < n; f++)
					y_mem[yi + f] = '0;
			end
			default: begin
				out.read_value = y_mem[yi + int'(r.feature_index)];
				out.overflow_seen = ovf_flag;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 100)
			$display("mismatch: %s got %h wanted %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic void add_step(input req_kind_t kind, input int row, input int col,
			input int feat, input logic [31:0] value, input bit typed = 1'b0,
			input logic [31:0] want_val = '0, input bit want_ovf = 1'b0);
		step_t s;
		s.is_cfg = 1'b0;
		s.cfg = '0;
		s.item.req_type = kind;
		s.item.row_index = 10'(row);
		s.item.col_index = 10'(col);
		s.item.feature_index = 4'(feat);
		s.item.value = value;
		s.typed = typed;
		s.want.read_value = want_val;
		s.want.overflow_seen = want_ovf;
		directed_steps.insert(directed_steps.size(), s);
	endfunction

	// offers one item and returns at the edge where it is taken
	task automatic send_item(input req_t item, input bit typed, input rsp_t want);
		read_note_t note;
		int         n;
		int         f;
		while (!no_idle && $urandom_range(0, 99) < 33) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		n = active_n(fc_gen);
		case (item.req_type)
			REQ_LOAD:  x_set[int'(item.col_index) * FMAX + int'(item.feature_index)] = 1'b1;
			REQ_CLEAR: for (f = 0; f < n; f++) y_set[int'(item.row_index) * FMAX + f] = 1'b1;
			default: ;
		endcase
		note.typed = typed;
		note.want = want;
		read_notes.insert(read_notes.size(), note);
		req <= item;
		req_valid <= 1'b1;
		items_sent++;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_feature_count(input logic [FC_W-1:0] fc);
		settle();
		cfg_data <= fc;
		cfg_valid <= 1'b1;
		fc_gen = fc;
		cfg_writes++;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		rsp_t       want;
		rsp_t       guess;
		read_note_t note;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_reads.size() == 0) begin
					report_mismatch("unexpected response", rsp.read_value, '0);
				end else begin
					want = expected_reads.pop_front();
					reads_checked++;
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", rsp.read_value, want.read_value);
					if (rsp.overflow_seen !== want.overflow_seen)
						report_mismatch("overflow_seen", 32'(rsp.overflow_seen),
							32'(want.overflow_seen));
				end
			end
			if (cfg_valid && cfg_ready)
				fc_model = cfg_data;
			if (req_valid && req_ready) begin
				note = read_notes.pop_front();
				if (spmm_predict(req, guess))
					expected_reads.insert(expected_reads.size(),
						note.typed ? note.want : guess);
			end
			if ((rsp_valid && rsp_ready) || (cfg_valid && cfg_ready) ||
					(req_valid && req_ready))
				dead_cycles = 0;
			else
				dead_cycles++;
		end
	end

	// response side stalls, plus one long hold when asked
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
				holds_done++;
			end
			rsp_ready <= no_idle || ($urandom_range(0, 99) >= 33);
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (dead_cycles < STALL_LIMIT) @(posedge clk);
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		step_t cfg_step;
		req_t  item;
		int    n;
		int    roll;
		int    xi;
		int    yi;
		int    f;
		arst_n = 1'b0;
		req = '0;
		req_valid = 1'b0;
		cfg_data = '0;
		cfg_valid = 1'b0;
		no_idle = 1'b0;
		hold_rsp = 1'b0;
		ovf_flag = 1'b0;
		fc_model = FEATURE_COUNT_RST;
		fc_gen = FEATURE_COUNT_RST;

		// reset feature count clears the whole row
		add_step(REQ_CLEAR, 0, 0, 0, '0);
		add_step(REQ_READ, 0, 0, 15, '0, 1'b1, 32'h0000_0000, 1'b0);
		add_step(REQ_READ, 0, 0, 0, '0, 1'b1, 32'h0000_0000, 1'b0);
		cfg_step.is_cfg = 1'b1;
		cfg_step.cfg = 5'd2;
		cfg_step.item = '0;
		cfg_step.typed = 1'b0;
		cfg_step.want = '0;
		directed_steps.insert(directed_steps.size(), cfg_step);
		add_step(REQ_LOAD, 0, 0, 0, 32'h0001_0000);
		add_step(REQ_LOAD, 0, 0, 1, 32'h0002_0000);
		add_step(REQ_ACCUM, 0, 0, 0, 32'h0003_0000);
		add_step(REQ_READ, 0, 0, 0, '0, 1'b1, 32'h0003_0000, 1'b0);
		add_step(REQ_READ, 0, 0, 1, '0, 1'b1, 32'h0006_0000, 1'b0);
		add_step(REQ_READ, 0, 0, 15, '0, 1'b1, 32'h0000_0000, 1'b0);
		// floor rounding of tiny products
		add_step(REQ_LOAD, 0, 5, 0, 32'hFFFF_FFFF);
		add_step(REQ_LOAD, 0, 5, 1, 32'h0000_0001);
		add_step(REQ_CLEAR, 7, 0, 0, '0);
		add_step(REQ_ACCUM, 7, 5, 0, 32'h0000_0001);
		add_step(REQ_READ, 7, 0, 0, '0, 1'b1, 32'hFFFF_FFFF, 1'b0);
		add_step(REQ_READ, 7, 0, 1, '0, 1'b1, 32'h0000_0000, 1'b0);
		// saturation both ways, flag goes sticky
		add_step(REQ_LOAD, 0, 1023, 0, 32'h7FFF_FFFF);
		add_step(REQ_LOAD, 0, 1023, 1, 32'h8000_0000);
		add_step(REQ_CLEAR, 1023, 0, 0, '0);
		add_step(REQ_ACCUM, 1023, 1023, 0, 32'h7FFF_FFFF);
		add_step(REQ_READ, 1023, 0, 0, '0, 1'b1, 32'h7FFF_FFFF, 1'b1);
		add_step(REQ_READ, 1023, 0, 1, '0, 1'b1, 32'h8000_0000, 1'b1);
		add_step(REQ_ACCUM, 0, 0, 0, 32'h8000_0000);
		add_step(REQ_READ, 0, 0, 0, '0);
		add_step(REQ_READ, 0, 0, 1, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg)
				write_feature_count(directed_steps[i].cfg);
			else
				send_item(directed_steps[i].item, directed_steps[i].typed,
					directed_steps[i].want);
		end

		for (int p = 0; p < NPHASES; p++) begin
			if (p == NPHASES - 1)
				write_feature_count(5'($urandom_range(1, 16)));
			else
				write_feature_count(PHASE_FC[p]);
			no_idle = (p == 2);
			if (p == 4)
				hold_rsp = 1'b1;
			for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
				n = active_n(fc_gen);
				roll = $urandom_range(0, 99);
				item.req_type = (roll < 25) ? REQ_LOAD : (roll < 60) ? REQ_ACCUM :
					(roll < 70) ? REQ_CLEAR : REQ_READ;
				item.row_index = pick_index();
				item.col_index = pick_index();
				item.feature_index = 4'($urandom_range(0, 15));
				roll = $urandom_range(0, 99);
				if (roll < 60)
					item.value = $urandom_range(0, 524288) - 262144;
				else if (roll < 85)
					item.value = $urandom;
				else
					item.value = EDGE_VALUES[$urandom_range(0, 4)];
				xi = int'(item.col_index) * FMAX;
				yi = int'(item.row_index) * FMAX;
				// fill in missing x or y entries before they are used
				if (item.req_type == REQ_ACCUM) begin
					for (f = n - 1; f >= 0; f--) begin
						if (!x_set[xi + f]) begin
							item.req_type = REQ_LOAD;
							item.feature_index = 4'(f);
						end
					end
					if (item.req_type == REQ_ACCUM)
						for (f = 0; f < n; f++)
							if (!y_set[yi + f])
								item.req_type = REQ_CLEAR;
				end else if (item.req_type == REQ_READ &&
						!y_set[yi + int'(item.feature_index)]) begin
					item.req_type = (n == 0) ? REQ_LOAD : REQ_CLEAR;
				end
				send_item(item, 1'b0, '0);
			end
			no_idle = 1'b0;
		end

		settle();
		$display("covered %0d items with %0d reads checked, %0d feature_count writes",
			items_sent, reads_checked, cfg_writes);
		$display("long response holds: %0d", holds_done);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/coo_sra_pkg.sv
src/coo_sra_queue.sv
src/coo_sra_front.sv
src/coo_sra_back.sv
src/coo_spmm_row_accumulate.sv
src/coo_sra_checker.sv
test/testbench.sv
